// ===== rtl/i2cmb_pkg.sv =====
// Package: shared types, constants and phase functions of the I2C master byte engine.
`timescale 1ns / 1ps

package i2cmb_pkg;

  localparam int DELAY_WIDTH = 16;
  localparam int PH_W        = 4;

  localparam logic [7:0] ACK_POLL_LIMIT = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

  // Command codes
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_START     = 3'd1;
  localparam logic [2:0] OP_STOP      = 3'd2;
  localparam logic [2:0] OP_WRITE     = 3'd3;
  localparam logic [2:0] OP_READ_ACK  = 3'd4;
  localparam logic [2:0] OP_READ_NACK = 3'd5;

  // Phase codes of the engine
  localparam logic [PH_W-1:0] PH_IDLE    = 4'd0;
  localparam logic [PH_W-1:0] PH_ST_A    = 4'd1;
  localparam logic [PH_W-1:0] PH_ST_B    = 4'd2;
  localparam logic [PH_W-1:0] PH_ST_C    = 4'd3;
  localparam logic [PH_W-1:0] PH_SP_A    = 4'd4;
  localparam logic [PH_W-1:0] PH_SP_B    = 4'd5;
  localparam logic [PH_W-1:0] PH_SP_C    = 4'd6;
  localparam logic [PH_W-1:0] PH_WR_LO   = 4'd7;
  localparam logic [PH_W-1:0] PH_WR_HI   = 4'd8;
  localparam logic [PH_W-1:0] PH_WR_TAIL = 4'd9;
  localparam logic [PH_W-1:0] PH_AK_REL  = 4'd10;
  localparam logic [PH_W-1:0] PH_AK_RISE = 4'd11;
  localparam logic [PH_W-1:0] PH_AK_POLL = 4'd12;
  localparam logic [PH_W-1:0] PH_RD_LO   = 4'd13;
  localparam logic [PH_W-1:0] PH_RD_HI   = 4'd14;
  localparam logic [PH_W-1:0] PH_RD_TAIL = 4'd15;

  typedef logic [DELAY_WIDTH-1:0] delay_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_fail;
  } out_item_t;

  typedef struct packed {
    logic [PH_W-1:0] ph;
    delay_t          tick;
    logic [3:0]      bit_idx;
    logic [7:0]      shift;
    logic [7:0]      poll;
    logic            nack;
    logic            scl;
    logic            sda;
    logic            drv;
    logic [7:0]      rx;
    logic            fail;
  } eng_state_t;

  // Enter a phase: set the lines it drives and load its length.
  function automatic eng_state_t enter_phase(input eng_state_t s, input logic [PH_W-1:0] ph,
                                             input delay_t half, input delay_t full);
    eng_state_t t;
    t      = s;
    t.ph   = ph;
    t.tick = delay_t'(1);
    unique case (ph)
      PH_ST_A: begin
        t.drv = 1'b1; t.sda = 1'b1; t.scl = 1'b1; t.tick = half;
      end
      PH_ST_B: begin
        t.sda = 1'b0; t.tick = full;
      end
      PH_ST_C: begin
        t.scl = 1'b0; t.tick = half;
      end
      PH_SP_A: begin
        t.drv = 1'b1; t.sda = 1'b0; t.scl = 1'b0; t.tick = half;
      end
      PH_SP_B: begin
        t.scl = 1'b1; t.tick = full;
      end
      PH_SP_C: begin
        t.sda = 1'b1; t.tick = half;
      end
      PH_WR_LO: begin
        t.drv   = 1'b1;
        t.scl   = 1'b0;
        t.sda   = s.shift[7];
        t.shift = {s.shift[6:0], 1'b0};
        t.tick  = half;
      end
      PH_WR_HI: begin
        t.scl = 1'b1; t.tick = full;
      end
      PH_WR_TAIL: begin
        t.scl = 1'b0; t.tick = half;
      end
      PH_AK_REL: begin
        t.drv = 1'b0; t.sda = 1'b1;
      end
      PH_AK_RISE: begin
        t.scl = 1'b1;
      end
      PH_AK_POLL: begin
        t.poll = 8'd0;
      end
      PH_RD_LO: begin
        t.scl = 1'b0;
        if (s.bit_idx < BITS_PER_BYTE) begin
          t.drv = 1'b0; t.sda = 1'b1;
        end else begin
          t.drv = 1'b1; t.sda = s.nack;
        end
        t.tick = half;
      end
      PH_RD_HI: begin
        t.scl = 1'b1; t.tick = full;
      end
      PH_RD_TAIL: begin
        t.scl = 1'b0; t.tick = half;
      end
      default: begin
        t.ph = PH_IDLE;
      end
    endcase
    return t;
  endfunction

  // Move on at the end of a phase; flag the end of the command.
  function automatic eng_state_t advance(input eng_state_t s, input delay_t half,
                                         input delay_t full, output logic done);
    eng_state_t t;
    logic [3:0] nb;
    t    = s;
    nb   = s.bit_idx + 4'd1;
    done = 1'b0;
    unique case (s.ph)
      PH_ST_A:    t = enter_phase(s, PH_ST_B, half, full);
      PH_ST_B:    t = enter_phase(s, PH_ST_C, half, full);
      PH_SP_A:    t = enter_phase(s, PH_SP_B, half, full);
      PH_SP_B:    t = enter_phase(s, PH_SP_C, half, full);
      PH_WR_LO:   t = enter_phase(s, PH_WR_HI, half, full);
      PH_WR_HI:   t = enter_phase(s, PH_WR_TAIL, half, full);
      PH_WR_TAIL: begin
        t.bit_idx = nb;
        t = enter_phase(t, (nb < BITS_PER_BYTE) ? PH_WR_LO : PH_AK_REL, half, full);
      end
      PH_AK_REL:  t = enter_phase(s, PH_AK_RISE, half, full);
      PH_AK_RISE: t = enter_phase(s, PH_AK_POLL, half, full);
      PH_RD_LO:   t = enter_phase(s, PH_RD_HI, half, full);
      PH_RD_HI:   t = enter_phase(s, PH_RD_TAIL, half, full);
      PH_RD_TAIL: begin
        if (s.bit_idx < BITS_PER_BYTE) begin
          t.bit_idx = nb;
          if (nb == BITS_PER_BYTE) begin
            t.rx = s.shift;
          end
          t = enter_phase(t, PH_RD_LO, half, full);
        end else begin
          t.ph = PH_IDLE;
          done = 1'b1;
        end
      end
      default: begin
        t.ph = PH_IDLE;
        done = 1'b1;
      end
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/i2cmb_in_if.sv =====
// Interface: command/tick input channel.
`timescale 1ns / 1ps

interface i2cmb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, output op, output tx_byte, output sda_in, input ready);
  modport sink (input valid, input op, input tx_byte, input sda_in, output ready);
endinterface

// ===== rtl/i2cmb_out_if.sv =====
// Interface: per-tick result channel.
`timescale 1ns / 1ps

interface i2cmb_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_fail;

  modport source (output valid, output scl, output sda_out, output sda_drive,
                  output busy_res, output done_res, output rx_byte, output ack_fail,
                  input ready);
  modport sink (input valid, input scl, input sda_out, input sda_drive,
                input busy_res, input done_res, input rx_byte, input ack_fail,
                output ready);
endinterface

// ===== rtl/i2cmb_cfg_if.sv =====
// Interface: bit delay configuration write channel.
`timescale 1ns / 1ps

interface i2cmb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [i2cmb_pkg::DELAY_WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/i2cmb_engine.sv =====
// Engine: phase state registers and the per-tick next-state and result logic.
`timescale 1ns / 1ps

module i2cmb_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  i2cmb_pkg::in_item_t   item,
  input  i2cmb_pkg::delay_t     bit_delay,
  output i2cmb_pkg::out_item_t  res
);
  import i2cmb_pkg::*;

  eng_state_t st_r;
  eng_state_t st_nxt;
  delay_t     half_len;
  delay_t     full_len;

  // Zero-length phases last one tick.
  always_comb begin
    half_len = bit_delay >> 1;
    if (half_len == '0) begin
      half_len = delay_t'(1);
    end
    full_len = (bit_delay == '0) ? delay_t'(1) : bit_delay;
  end

  always_comb begin
    eng_state_t s;
    logic       adv_done;
    s        = st_r;
    adv_done = 1'b0;
    res      = '0;

    // Take a command only when idle.
    if (s.ph == PH_IDLE) begin
      unique case (item.op)
        OP_START: s = enter_phase(s, PH_ST_A, half_len, full_len);
        OP_STOP:  s = enter_phase(s, PH_SP_A, half_len, full_len);
        OP_WRITE: begin
          s.shift   = item.tx_byte;
          s.bit_idx = 4'd0;
          s.fail    = 1'b0;
          s.poll    = 8'd0;
          s = enter_phase(s, PH_WR_LO, half_len, full_len);
        end
        OP_READ_ACK, OP_READ_NACK: begin
          s.shift   = 8'd0;
          s.bit_idx = 4'd0;
          s.nack    = (item.op == OP_READ_NACK);
          s = enter_phase(s, PH_RD_LO, half_len, full_len);
        end
        default: begin
        end
      endcase
    end

    res.scl       = s.scl;
    res.sda_out   = s.sda;
    res.sda_drive = s.drv;

    if (s.ph != PH_IDLE) begin
      res.busy_res = 1'b1;
      if (s.ph == PH_AK_POLL) begin
        if (!item.sda_in) begin
          s.scl        = 1'b0;
          s.ph         = PH_IDLE;
          res.done_res = 1'b1;
        end else if (s.poll >= ACK_POLL_LIMIT) begin
          s.fail = 1'b1;
          s = enter_phase(s, PH_SP_A, half_len, full_len);
        end else begin
          s.poll = s.poll + 8'd1;
        end
      end else begin
        // Sample SDA on the last tick of a data bit's high phase.
        if (s.ph == PH_RD_HI && s.bit_idx < BITS_PER_BYTE && s.tick <= delay_t'(1)) begin
          s.shift = {s.shift[6:0], item.sda_in};
        end
        if (s.tick > delay_t'(1)) begin
          s.tick = s.tick - delay_t'(1);
        end else begin
          s.tick = '0;
          s = advance(s, half_len, full_len, adv_done);
          res.done_res = adv_done;
        end
      end
    end

    res.rx_byte  = s.rx;
    res.ack_fail = s.fail;
    st_nxt       = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.ph      <= PH_IDLE;
      st_r.tick    <= '0;
      st_r.bit_idx <= 4'd0;
      st_r.shift   <= 8'd0;
      st_r.poll    <= 8'd0;
      st_r.nack    <= 1'b0;
      st_r.scl     <= 1'b1;
      st_r.sda     <= 1'b1;
      st_r.drv     <= 1'b1;
      st_r.rx      <= 8'd0;
      st_r.fail    <= 1'b0;
    end else if (acc) begin
      st_r <= st_nxt;
    end
  end

  a_poll_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.poll <= ACK_POLL_LIMIT)
    else $error("acknowledge poll count past its limit");

  a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bit_idx <= BITS_PER_BYTE)
    else $error("bit index past one byte");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res.done_res) |=> (st_r.ph == PH_IDLE))
    else $error("command finished but engine not idle");

  a_fail_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.fail) |-> ($past(acc) && $past(st_r.ph) == PH_AK_POLL))
    else $error("ack failure raised outside an acknowledge poll");

endmodule

// ===== rtl/i2c_master_byte_controller_top.sv =====
// Top level: I2C master byte controller with tick input, result register and delay register.
`timescale 1ns / 1ps

// Usage
//   in_ch  : one transaction per bus tick: op (none/start/stop/write/read+ACK/
//            read+NACK), tx_byte for writes, and the sampled SDA level.
//   out_ch : one transaction per accepted tick: SCL and SDA levels to drive,
//            SDA drive enable, busy/done flags, last read byte, ack failure.
//   cfg_ch : write the SCL high time in ticks (low phases use half of it).
//            Write only while no command runs and all results are taken.
// The result of a tick appears on out_ch in the cycle after the tick is accepted.
//   Throughput: one tick per clock unless out_ch stalls; the engine's phase
//   update is a single registered step, and the result register decouples the
//   channels so a new tick is taken while the previous result is taken.
// Commands arriving while busy are ignored; ack polling times out after
//   ACK_POLL_LIMIT+1 high polls and ends the write with a stop condition.
// Reset (rst_n low, synchronous): engine idle, SCL/SDA high and driven,
//   bit delay back to 10 ticks, no result pending.
// Stall: when out_ch.ready is low with a result held, in_ch.ready drops and
//   the engine holds its state until the result is taken.

module i2c_master_byte_controller_top (
  input logic       clk,
  input logic       rst_n,
  i2cmb_in_if.sink  in_ch,
  i2cmb_out_if.source out_ch,
  i2cmb_cfg_if.sink cfg_ch
);
  import i2cmb_pkg::*;

  delay_t    bit_delay_r;
  logic      out_valid_r;
  out_item_t res_r;
  out_item_t res;
  in_item_t  item;
  logic      acc;

  // Accept a tick whenever the result register is empty or being drained.
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign acc          = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign item.op      = in_ch.op;
  assign item.tx_byte = in_ch.tx_byte;
  assign item.sda_in  = in_ch.sda_in;

  i2cmb_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .item      (item),
    .bit_delay (bit_delay_r),
    .res       (res)
  );

  // Bit delay register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_delay_r <= delay_t'(10);
    end else if (cfg_ch.valid) begin
      bit_delay_r <= cfg_ch.data;
    end
  end

  // Result register: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl       = res_r.scl;
  assign out_ch.sda_out   = res_r.sda_out;
  assign out_ch.sda_drive = res_r.sda_drive;
  assign out_ch.busy_res  = res_r.busy_res;
  assign out_ch.done_res  = res_r.done_res;
  assign out_ch.rx_byte   = res_r.rx_byte;
  assign out_ch.ack_fail  = res_r.ack_fail;

endmodule

// ===== tb/i2c_master_byte_controller_top_test.sv =====
// Testbench: per-tick scoreboard check of the I2C master byte controller under random stalls.
`timescale 1ns / 1ps

module i2c_master_byte_controller_top_test;
  import i2cmb_pkg::*;

  // Track the bus lines tick by tick and hold the expected result of every accepted tick.
  class bus_tick_scoreboard;
    delay_t          bit_delay;
    logic [PH_W-1:0] ph;
    int unsigned     ticks_left;
    logic [3:0]      bit_idx;
    logic [7:0]      shreg;
    logic [7:0]      polls;
    logic [7:0]      rx;
    logic            nack;
    logic            scl;
    logic            sda;
    logic            drv;
    logic            fail;
    out_item_t       expected_ticks[$];
    int              mismatches;
    int              ticks_checked;

    function new();
      bit_delay     = 16'd10;
      ph            = PH_IDLE;
      ticks_left    = 0;
      bit_idx       = 4'd0;
      shreg         = 8'd0;
      polls         = 8'd0;
      rx            = 8'd0;
      nack          = 1'b0;
      scl           = 1'b1;
      sda           = 1'b1;
      drv           = 1'b1;
      fail          = 1'b0;
      mismatches    = 0;
      ticks_checked = 0;
    endfunction

    function void set_bit_delay(delay_t v);
      bit_delay = v;
    endfunction

    // Zero-length phases stretch to one tick.
    function int unsigned half_ticks();
      int unsigned h;
      h = 32'(bit_delay >> 1);
      return (h == 0) ? 1 : h;
    endfunction

    function int unsigned full_ticks();
      return (bit_delay == 0) ? 1 : 32'(bit_delay);
    endfunction

    function void load_phase(logic [PH_W-1:0] nxt);
      ph         = nxt;
      ticks_left = 1;
      case (nxt)
        PH_ST_A: begin
          drv = 1'b1; sda = 1'b1; scl = 1'b1; ticks_left = half_ticks();
        end
        PH_ST_B: begin
          sda = 1'b0; ticks_left = full_ticks();
        end
        PH_ST_C: begin
          scl = 1'b0; ticks_left = half_ticks();
        end
        PH_SP_A: begin
          drv = 1'b1; sda = 1'b0; scl = 1'b0; ticks_left = half_ticks();
        end
        PH_SP_B: begin
          scl = 1'b1; ticks_left = full_ticks();
        end
        PH_SP_C: begin
          sda = 1'b1; ticks_left = half_ticks();
        end
        PH_WR_LO: begin
          drv        = 1'b1;
          scl        = 1'b0;
          sda        = shreg[7];
          shreg      = {shreg[6:0], 1'b0};
          ticks_left = half_ticks();
        end
        PH_WR_HI: begin
          scl = 1'b1; ticks_left = full_ticks();
        end
        PH_WR_TAIL: begin
          scl = 1'b0; ticks_left = half_ticks();
        end
        PH_AK_REL: begin
          drv = 1'b0; sda = 1'b1;
        end
        PH_AK_RISE: begin
          scl = 1'b1;
        end
        PH_AK_POLL: begin
          polls = 8'd0;
        end
        PH_RD_LO: begin
          scl = 1'b0;
          if (bit_idx < BITS_PER_BYTE) begin
            drv = 1'b0; sda = 1'b1;
          end else begin
            drv = 1'b1; sda = nack;
          end
          ticks_left = half_ticks();
        end
        PH_RD_HI: begin
          scl = 1'b1; ticks_left = full_ticks();
        end
        PH_RD_TAIL: begin
          scl = 1'b0; ticks_left = half_ticks();
        end
        default: begin
          ph = PH_IDLE;
        end
      endcase
    endfunction

    // Step to the next phase at the end of one; return 1 when the command is over.
    function bit next_phase();
      case (ph)
        PH_ST_A: begin
          load_phase(PH_ST_B); return 1'b0;
        end
        PH_ST_B: begin
          load_phase(PH_ST_C); return 1'b0;
        end
        PH_SP_A: begin
          load_phase(PH_SP_B); return 1'b0;
        end
        PH_SP_B: begin
          load_phase(PH_SP_C); return 1'b0;
        end
        PH_WR_LO: begin
          load_phase(PH_WR_HI); return 1'b0;
        end
        PH_WR_HI: begin
          load_phase(PH_WR_TAIL); return 1'b0;
        end
        PH_WR_TAIL: begin
          bit_idx = bit_idx + 4'd1;
          load_phase((bit_idx < BITS_PER_BYTE) ? PH_WR_LO : PH_AK_REL);
          return 1'b0;
        end
        PH_AK_REL: begin
          load_phase(PH_AK_RISE); return 1'b0;
        end
        PH_AK_RISE: begin
          load_phase(PH_AK_POLL); return 1'b0;
        end
        PH_RD_LO: begin
          load_phase(PH_RD_HI); return 1'b0;
        end
        PH_RD_HI: begin
          load_phase(PH_RD_TAIL); return 1'b0;
        end
        PH_RD_TAIL: begin
          if (bit_idx < BITS_PER_BYTE) begin
            bit_idx = bit_idx + 4'd1;
            if (bit_idx == BITS_PER_BYTE) rx = shreg;
            load_phase(PH_RD_LO);
            return 1'b0;
          end
        end
        default: ;
      endcase
      ph = PH_IDLE;
      return 1'b1;
    endfunction

    // Advance the engine by one accepted tick and queue the lines it produces.
    function void note_tick(in_item_t it);
      out_item_t e;
      logic      busy;
      logic      done;
      busy = 1'b0;
      done = 1'b0;
      if (ph == PH_IDLE) begin
        case (it.op)
          OP_START: load_phase(PH_ST_A);
          OP_STOP:  load_phase(PH_SP_A);
          OP_WRITE: begin
            shreg   = it.tx_byte;
            bit_idx = 4'd0;
            fail    = 1'b0;
            polls   = 8'd0;
            load_phase(PH_WR_LO);
          end
          OP_READ_ACK, OP_READ_NACK: begin
            shreg   = 8'd0;
            bit_idx = 4'd0;
            nack    = (it.op == OP_READ_NACK);
            load_phase(PH_RD_LO);
          end
          default: ;
        endcase
      end
      e.scl       = scl;
      e.sda_out   = sda;
      e.sda_drive = drv;
      if (ph != PH_IDLE) begin
        busy = 1'b1;
        if (ph == PH_AK_POLL) begin
          if (!it.sda_in) begin
            scl  = 1'b0;
            ph   = PH_IDLE;
            done = 1'b1;
          end else if (polls >= ACK_POLL_LIMIT) begin
            fail = 1'b1;
            load_phase(PH_SP_A);
          end else begin
            polls = polls + 8'd1;
          end
        end else begin
          if (ph == PH_RD_HI && bit_idx < BITS_PER_BYTE && ticks_left <= 1)
            shreg = {shreg[6:0], it.sda_in};
          if (ticks_left > 1) begin
            ticks_left = ticks_left - 1;
          end else begin
            ticks_left = 0;
            done       = next_phase();
          end
        end
      end
      e.busy_res = busy;
      e.done_res = done;
      e.rx_byte  = rx;
      e.ack_fail = fail;
      expected_ticks.push_back(e);
    endfunction

    function void compare_field(string field, logic [7:0] e, logic [7:0] a);
      if (a !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tick %0d: %s expected %0h, got %0h", ticks_checked, field, e, a);
      end
    endfunction

    function void check_tick(out_item_t got);
      out_item_t e;
      if (expected_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tick %0d: result with nothing expected", ticks_checked);
        ticks_checked++;
        return;
      end
      e = expected_ticks.pop_front();
      compare_field("scl", 8'(e.scl), 8'(got.scl));
      compare_field("sda_out", 8'(e.sda_out), 8'(got.sda_out));
      compare_field("sda_drive", 8'(e.sda_drive), 8'(got.sda_drive));
      compare_field("busy_res", 8'(e.busy_res), 8'(got.busy_res));
      compare_field("done_res", 8'(e.done_res), 8'(got.done_res));
      compare_field("rx_byte", e.rx_byte, got.rx_byte);
      compare_field("ack_fail", 8'(e.ack_fail), 8'(got.ack_fail));
      ticks_checked++;
    endfunction
  endclass

  // Codes the engine must ignore as commands
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int IDLE_PCT     = 19;
  localparam int STALL_CYCLES = 400;
  // Ack wait value that keeps SDA high on every poll, forcing the timeout
  localparam int ACK_NEVER    = 255;
  // Ack wait value that leaves SDA random during polling
  localparam int ACK_RANDOM   = -1;

  logic clk = 1'b0;
  logic rst_n;

  i2cmb_in_if  in_ch ();
  i2cmb_out_if out_ch ();
  i2cmb_cfg_if cfg_ch ();

  bus_tick_scoreboard sb = new();

  // Shared knobs: the stimulus sets want_hold and no_idle, the result side reads them.
  bit want_hold = 1'b0;
  bit no_idle   = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  i2c_master_byte_controller_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random backpressure, plus one long hold-off while the sender keeps offering,
  // so the result register fills and the input channel has to stall.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (want_hold && !hold_done) begin
      hold_done = 1'b1;
      hold_left = STALL_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Check every result transaction against the oldest expected tick.
  always @(posedge clk) begin
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.scl       = out_ch.scl;
      got.sda_out   = out_ch.sda_out;
      got.sda_drive = out_ch.sda_drive;
      got.busy_res  = out_ch.busy_res;
      got.done_res  = out_ch.done_res;
      got.rx_byte   = out_ch.rx_byte;
      got.ack_fail  = out_ch.ack_fail;
      sb.check_tick(got);
    end
  end

  // Offer one tick, idling at random first; return once the transaction is taken.
  // Enter and leave right after a rising edge.
  task automatic push_tick(input in_item_t it);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= it.op;
    in_ch.tx_byte <= it.tx_byte;
    in_ch.sda_in  <= it.sda_in;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_tick(it);
  endtask

  // Issue one command on an idle engine, then tick until it finishes.
  // ack_wait: high polls before the slave pulls SDA low (ACK_NEVER times out,
  // ACK_RANDOM leaves SDA random). noise: percent of busy ticks that carry a nonzero op code.
  task automatic run_command(input logic [2:0] op, input logic [7:0] tx, input int ack_wait,
                             input int noise);
    in_item_t it;
    it.op      = op;
    it.tx_byte = tx;
    it.sda_in  = 1'($urandom_range(0, 1));
    push_tick(it);
    while (sb.ph != PH_IDLE) begin
      it.op      = ($urandom_range(0, 99) < noise) ? 3'($urandom_range(1, 7)) : OP_NONE;
      it.tx_byte = 8'($urandom);
      if (sb.ph == PH_AK_POLL && ack_wait >= 0)
        it.sda_in = (sb.polls < ack_wait);
      else
        it.sda_in = 1'($urandom_range(0, 1));
      push_tick(it);
    end
  endtask

  // Tick the engine back to idle, drop valid and wait until every result is in.
  task automatic settle();
    in_item_t it;
    while (sb.ph != PH_IDLE) begin
      it.op      = OP_NONE;
      it.tx_byte = 8'($urandom);
      it.sda_in  = 1'($urandom_range(0, 1));
      push_tick(it);
    end
    in_ch.valid <= 1'b0;
    while (sb.expected_ticks.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write the bit delay; call only with the engine idle and no result pending.
  task automatic write_bit_delay(input delay_t v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_bit_delay(v);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random command mix with short acknowledge waits; count only real commands.
  task automatic run_mix(input int n);
    int         cmds;
    int         r;
    int         ack_wait;
    logic [2:0] op;
    cmds = 0;
    while (cmds < n) begin
      r = $urandom_range(0, 99);
      if (r < 4)       op = OP_NONE;
      else if (r < 8)  op = ($urandom_range(0, 1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
      else if (r < 23) op = OP_START;
      else if (r < 38) op = OP_STOP;
      else if (r < 68) op = OP_WRITE;
      else if (r < 84) op = OP_READ_ACK;
      else             op = OP_READ_NACK;
      r = $urandom_range(0, 99);
      if (r < 60)      ack_wait = $urandom_range(0, 3);
      else if (r < 80) ack_wait = $urandom_range(4, 12);
      else             ack_wait = ACK_RANDOM;
      run_command(op, 8'($urandom), ack_wait, 4);
      if (op >= OP_START && op <= OP_READ_NACK) cmds++;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_NONE;
    in_ch.tx_byte  = 8'd0;
    in_ch.sda_in   = 1'b1;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at the reset bit delay: short commands only.
    run_command(OP_NONE, 8'h00, 0, 0);
    run_command(OP_START, 8'h00, 0, 0);
    run_command(OP_STOP, 8'h7E, 0, 0);
    run_command(OP_SPARE_6, 8'h00, 0, 0);
    run_command(OP_SPARE_7, 8'hFF, 0, 0);
    settle();

    // One-tick phases, no idling on either side for the whole stretch.
    write_bit_delay(16'd1);
    no_idle <= 1'b1;
    run_command(OP_WRITE, 8'h5A, ACK_NEVER, 0);         // no ack: fail flag and stop
    run_command(OP_WRITE, 8'h3C, 0, 0);                 // new write clears the flag
    run_command(OP_READ_ACK, 8'h00, 0, 0);
    run_command(OP_READ_NACK, 8'hFF, 0, 0);
    run_command(OP_START, 8'h81, 0, 100);               // every busy tick carries a nonzero op code
    run_command(OP_STOP, 8'h7E, 0, 0);
    settle();
    no_idle <= 1'b0;

    // Zero delay stretches every phase to one tick
    write_bit_delay(16'd0);
    run_command(OP_START, 8'h00, 0, 0);
    run_command(OP_WRITE, 8'h81, ACK_RANDOM, 0);
    settle();

    // Shortest delay with no phase stretched; start the long receiver hold-off mid-stream.
    write_bit_delay(16'd2);
    run_mix(3);
    want_hold <= 1'b1;
    run_mix(3);
    settle();

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_ticks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #100000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
